[sv/box_downsample_2x2_argb_unit_macros.svh]
// Assertion macros shared by the 2x2 box downsampler RTL.
// Include by bare file name; the macros use clk_i and rst_ni of the including module.
`ifndef BOX_DOWNSAMPLE_2X2_ARGB_UNIT_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_ARGB_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BOXDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BOXDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/boxds_pkg.sv]
// Package of the 2x2 box downsampler: sizes, the command type passed from front to back,
// and the lane arithmetic. Used by every module of the block; depends on nothing.
package boxds_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int DIM_W       = 13;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int LINE_DEPTH  = MAX_WIDTH / 2;
  localparam int LIDX_W      = $clog2(LINE_DEPTH);
  localparam int LANES       = 4;
  localparam int LANE_W      = 8;
  localparam int LSUM_W      = LANE_W + 1;
  localparam int PIX_W       = LANES * LANE_W;
  localparam int SUM_W       = LANES * LSUM_W;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  // Register byte addresses.
  localparam logic [APB_AW-1:0] REG_SRC_WIDTH  = APB_AW'(0);
  localparam logic [APB_AW-1:0] REG_SRC_HEIGHT = APB_AW'(4);

  // One pair sum on its way to the back end: either stored for the row below or emitted.
  typedef struct packed {
    logic              emit;
    logic [LIDX_W-1:0] idx;
    logic [SUM_W-1:0]  sum;
    logic              row_end;
    logic              frame_end;
  } cmd_t;

  // Zero counts as one; anything above the limit is clamped to it.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Lane-wise sum of two pixels into four 9-bit fields.
  function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = '0;
    for (int l = 0; l < LANES; l++) begin
      s[l*LSUM_W +: LSUM_W] = LSUM_W'(a[l*LANE_W +: LANE_W]) +
                              LSUM_W'(b[l*LANE_W +: LANE_W]);
    end
    return s;
  endfunction

  // Adds two pair sums lane-wise and divides each lane by four.
  function automatic logic [PIX_W-1:0] average4(input logic [SUM_W-1:0] top,
                                                input logic [SUM_W-1:0] bot);
    logic [PIX_W-1:0]  p;
    logic [LSUM_W:0]   t;
    p = '0;
    for (int l = 0; l < LANES; l++) begin
      t = (LSUM_W+1)'(top[l*LSUM_W +: LSUM_W]) + (LSUM_W+1)'(bot[l*LSUM_W +: LSUM_W]);
      p[l*LANE_W +: LANE_W] = t[LSUM_W:2];
    end
    return p;
  endfunction

endpackage

[sv/boxds_front.sv]
// Front end of the 2x2 box downsampler: takes pixel beats, tracks the source position,
// pairs columns and issues commands. Depends on boxds_pkg.
module boxds_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [boxds_pkg::PIX_W-1:0]   s_tdata,
  input  logic [boxds_pkg::DIM_W-1:0]   src_width_i,
  input  logic [boxds_pkg::DIM_W-1:0]   src_height_i,
  input  logic                          restart_i,
  input  logic                          full_i,
  output logic                          push_o,
  output boxds_pkg::cmd_t               cmd_o
);

  logic [boxds_pkg::COL_W-1:0] col_q, col_d;
  logic [boxds_pkg::ROW_W-1:0] row_q, row_d;
  logic [boxds_pkg::PIX_W-1:0] held_q;
  logic [boxds_pkg::DIM_W-1:0] w, h;
  logic [boxds_pkg::DIM_W-2:0] half_w_m1, half_h_m1;
  logic                        accept, last_col, last_row, col_wrap, row_wrap;

  assign w = boxds_pkg::eff_dim(src_width_i, boxds_pkg::DIM_W'(boxds_pkg::MAX_WIDTH));
  assign h = boxds_pkg::eff_dim(src_height_i, boxds_pkg::DIM_W'(boxds_pkg::MAX_HEIGHT));

  // Index of the last destination column and row; unreachable when the size is below two.
  assign half_w_m1 = w[boxds_pkg::DIM_W-1:1] - (boxds_pkg::DIM_W-1)'(1);
  assign half_h_m1 = h[boxds_pkg::DIM_W-1:1] - (boxds_pkg::DIM_W-1)'(1);

  assign s_tready = !full_i;
  assign accept   = s_tvalid && s_tready;

  assign last_col = {1'b0, col_q[boxds_pkg::COL_W-1:1]} == half_w_m1;
  assign last_row = {1'b0, row_q[boxds_pkg::ROW_W-1:1]} == half_h_m1;
  assign col_wrap = ({1'b0, col_q} + boxds_pkg::DIM_W'(1)) >= w;
  assign row_wrap = ({1'b0, row_q} + boxds_pkg::DIM_W'(1)) >= h;

  // Odd columns complete a pair; even rows store it, odd rows emit.
  assign push_o          = accept && col_q[0];
  assign cmd_o.emit      = row_q[0];
  assign cmd_o.idx       = col_q[boxds_pkg::COL_W-1:1];
  assign cmd_o.sum       = boxds_pkg::pair_sum(held_q, s_tdata);
  assign cmd_o.row_end   = last_col;
  assign cmd_o.frame_end = last_col && last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + boxds_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + boxds_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !col_q[0]) begin
      held_q <= s_tdata;
    end
  end

endmodule

[sv/boxds_queue.sv]
// Two-entry command queue between the front and back ends of the downsampler.
// Depends on boxds_pkg and the shared assertion macros.
`include "box_downsample_2x2_argb_unit_macros.svh"

module boxds_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  boxds_pkg::cmd_t push_cmd_i,
  input  logic            pop_i,
  output boxds_pkg::cmd_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  boxds_pkg::cmd_t              slots_q [boxds_pkg::QDEPTH];
  logic [boxds_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [boxds_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign head_o  = slots_q[rd_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == boxds_pkg::QCNT_W'(boxds_pkg::QDEPTH);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + boxds_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - boxds_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == boxds_pkg::QPTR_W'(boxds_pkg::QDEPTH - 1)) ? '0 :
                wr_q + boxds_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == boxds_pkg::QPTR_W'(boxds_pkg::QDEPTH - 1)) ? '0 :
                rd_q + boxds_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_cmd_i;
    end
  end

  `BOXDS_ASSERT_NOW(a_no_overflow, push_i, !full_o, "command pushed into a full queue")
  `BOXDS_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "command popped from an empty queue")

endmodule

[sv/boxds_back.sv]
// Back end of the downsampler: owns the line store of pair sums, reads it for odd rows
// and produces the averaged pixel beats. Depends on boxds_pkg and the assertion macros.
`include "box_downsample_2x2_argb_unit_macros.svh"

module boxds_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  boxds_pkg::cmd_t             head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [boxds_pkg::PIX_W-1:0] m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);

  logic [boxds_pkg::SUM_W-1:0] line_mem [boxds_pkg::LINE_DEPTH];

  // Stage one: stored sum of the row above, this row's sum and the flags.
  logic                        s1_valid_q;
  logic [boxds_pkg::SUM_W-1:0] top_q, bot_q;
  logic                        s1_row_end_q, s1_frame_end_q;

  // Output register.
  logic                        out_valid_q;
  logic [boxds_pkg::PIX_W-1:0] out_pix_q;
  logic                        out_row_end_q, out_frame_end_q;

  logic out_load, s1_free, pop_emit, pop_store;

  assign out_load  = s1_valid_q && (!out_valid_q || m_tready);
  assign s1_free   = !s1_valid_q || out_load;
  assign pop_o     = !empty_i && (!head_i.emit || s1_free);
  assign pop_emit  = pop_o && head_i.emit;
  assign pop_store = pop_o && !head_i.emit;

  always_ff @(posedge clk_i) begin
    if (pop_store) begin
      line_mem[head_i.idx] <= head_i.sum;
    end
    if (pop_emit) begin
      top_q <= line_mem[head_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_emit) begin
      bot_q          <= head_i.sum;
      s1_row_end_q   <= head_i.row_end;
      s1_frame_end_q <= head_i.frame_end;
    end
    if (out_load) begin
      out_pix_q       <= boxds_pkg::average4(top_q, bot_q);
      out_row_end_q   <= s1_row_end_q;
      out_frame_end_q <= s1_frame_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_emit) begin
        s1_valid_q <= 1'b1;
      end else if (out_load) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_pix_q;
  assign m_tlast  = out_row_end_q;
  assign m_tuser  = out_frame_end_q;

  `BOXDS_ASSERT_NEXT(a_s1_holds, s1_valid_q && out_valid_q && !m_tready, s1_valid_q, "stage one lost a stalled result")

endmodule

[sv/box_downsample_2x2_argb_unit.sv]
// Top level of the 2x2 box downsampler: configuration registers and the wiring of
// front end, command queue and back end. Depends on boxds_pkg and the three submodules.
//
// The unit takes a source image as a raster stream of 32-bit pixels, one beat per pixel,
// and emits one averaged pixel for every 2x2 block: each byte lane is the sum of its four
// samples divided by four, truncated. A trailing odd column or odd row is dropped, and a
// width or height of one gives no output at all. m_tlast marks the last pixel of each
// destination row and m_tuser the last pixel of the frame. The source size lives in two
// registers on the APB port (width at byte address 0, height at 4, 13 bits each, reset
// 4096, clamped to 4096, zero taken as one); writing either one restarts the frame at the
// top left corner, so it should only be written while no pixel is in flight. The input
// takes one beat every clock for as long as the two-entry command queue has room; the
// back end drains one command per clock, so at full rate nothing stalls unless the
// consumer holds m_tready low. After the beat of the odd pixel that completes its block,
// a result passes through the queue, the registered read of the line store of pair sums
// and the output register on its way out. The line store needs no clearing:
// every entry is written on an even row before the odd row below reads it.
module box_downsample_2x2_argb_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Source pixels.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [boxds_pkg::PIX_W-1:0]   s_tdata,   // [31:0] pixel_in
  // Averaged pixels.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [boxds_pkg::PIX_W-1:0]   m_tdata,   // [31:0] pixel_out
  output logic                          m_tlast,   // row_end
  output logic                          m_tuser,   // [0] frame_end
  // Configuration.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [boxds_pkg::APB_AW-1:0]  paddr,
  input  logic [boxds_pkg::APB_DW-1:0]  pwdata,
  output logic [boxds_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  logic [boxds_pkg::DIM_W-1:0] src_width_q, src_height_q;
  logic                        cfg_wr, push, pop, q_empty, q_full;
  boxds_pkg::cmd_t             push_cmd, head_cmd;

  // The register is selected by address bit two; the low address bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= boxds_pkg::DIM_W'(boxds_pkg::MAX_WIDTH);
      src_height_q <= boxds_pkg::DIM_W'(boxds_pkg::MAX_HEIGHT);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        src_height_q <= pwdata[boxds_pkg::DIM_W-1:0];
      end else begin
        src_width_q <= pwdata[boxds_pkg::DIM_W-1:0];
      end
    end
  end

  always_comb begin
    unique case ({paddr[2], 2'b00})
      boxds_pkg::REG_SRC_WIDTH:  prdata = boxds_pkg::APB_DW'(src_width_q);
      boxds_pkg::REG_SRC_HEIGHT: prdata = boxds_pkg::APB_DW'(src_height_q);
      default:                   prdata = '0;
    endcase
  end

  boxds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .restart_i    (cfg_wr),
    .full_i       (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  boxds_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  boxds_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head_cmd),
    .empty_i  (q_empty),
    .pop_o    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

[verif/box_downsample_2x2_argb_unit_tb.sv]
// Self-checking testbench for box_downsample_2x2_argb_unit: drives pixel beats and APB size
// writes, predicts every averaged pixel with its own line store model, and checks the outputs.
// Depends on boxds_pkg and the RTL of box_downsample_2x2_argb_unit only.
module box_downsample_2x2_argb_unit_tb;
  import boxds_pkg::*;

  // One expected beat on the master side.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } avg_beat_t;

  // Keeps its own copy of the frame position, the held even-column pixel and the line of
  // pair sums, and turns every accepted source pixel into zero or one expected beats.
  class downsample_scoreboard;
    logic [SUM_W-1:0] pair_line [LINE_DEPTH];
    logic [PIX_W-1:0] held_px;
    int unsigned      col;
    int unsigned      row;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    avg_beat_t        pending[$];
    int unsigned      mismatches;

    function new();
      held_px    = '0;
      col        = 0;
      row        = 0;
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      mismatches = 0;
    endfunction

    // A size write also sends the frame position back to the top left corner.
    function void set_size(input bit is_height, input logic [DIM_W-1:0] value);
      if (is_height) begin
        height_reg = value;
      end else begin
        width_reg = value;
      end
      col = 0;
      row = 0;
    endfunction

    function int unsigned usable_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
      int unsigned d;
      d = v;
      if (d == 0) begin
        d = 1;
      end else if (d > lim) begin
        d = lim;
      end
      return d;
    endfunction

    function logic [SUM_W-1:0] lane_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
      logic [SUM_W-1:0] s;
      for (int l = 0; l < LANES; l++) begin
        s[l*LSUM_W +: LSUM_W] = {1'b0, a[l*LANE_W +: LANE_W]} + {1'b0, b[l*LANE_W +: LANE_W]};
      end
      return s;
    endfunction

    function logic [PIX_W-1:0] quarter_of(input logic [SUM_W-1:0] top,
                                          input logic [SUM_W-1:0] bot);
      logic [PIX_W-1:0]  p;
      logic [LSUM_W:0]   t;
      for (int l = 0; l < LANES; l++) begin
        t = {1'b0, top[l*LSUM_W +: LSUM_W]} + {1'b0, bot[l*LSUM_W +: LSUM_W]};
        p[l*LANE_W +: LANE_W] = t[LSUM_W:2];
      end
      return p;
    endfunction

    function void note_source_pixel(input logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      slot;
      logic [SUM_W-1:0] s;
      avg_beat_t        beat;
      w = usable_dim(width_reg, MAX_WIDTH);
      h = usable_dim(height_reg, MAX_HEIGHT);
      if (col[0] == 1'b0) begin
        held_px = px;
      end else begin
        slot = (col >> 1) % LINE_DEPTH;
        s    = lane_pair(held_px, px);
        if (row[0] == 1'b0) begin
          pair_line[slot] = s;
        end else begin
          beat.pixel     = quarter_of(pair_line[slot], s);
          beat.row_end   = ((col >> 1) == (w >> 1) - 1);
          beat.frame_end = beat.row_end && ((row >> 1) == (h >> 1) - 1);
          pending.push_back(beat);
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) begin
          row = 0;
        end
      end
    endfunction

    function void check_averaged_pixel(input logic [PIX_W-1:0] px, input logic row_end,
                                       input logic frame_end);
      avg_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: averaged pixel expected none, got %08h", $time, px);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (want.pixel !== px) begin
        $display("%0t: pixel_out expected %08h, got %08h", $time, want.pixel, px);
        mismatches++;
      end
      if (want.row_end !== row_end) begin
        $display("%0t: row_end expected %0b, got %0b", $time, want.row_end, row_end);
        mismatches++;
      end
      if (want.frame_end !== frame_end) begin
        $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end, frame_end);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_tvalid;
  logic               s_tready;
  logic [PIX_W-1:0]   s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [PIX_W-1:0]   m_tdata;
  logic               m_tlast;
  logic               m_tuser;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  downsample_scoreboard sb = new();

  // Traffic shaping shared between the source driver and the sink process.
  bit quiet_tail       = 1'b0;  // no idling on either side in the closing stretch
  bit hold_off_request = 1'b0;  // asks the sink for one long stall
  int tx_idle_odds     = 0;     // one gap burst in this many beats; zero means none
  int random_items     = 0;

  box_downsample_2x2_argb_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [31:0] pixel_in
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [31:0] pixel_out
    .m_tlast  (m_tlast),   // row_end
    .m_tuser  (m_tuser),   // [0] frame_end
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Both handshakes are sampled at the rising edge, where the values seen are the ones
  // the edge acted upon, since every driver here and in the block updates by NBA.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        sb.note_source_pixel(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        sb.check_averaged_pixel(m_tdata, m_tlast, m_tuser);
      end
    end
  end

  // Sink side. Random stall bursts, one long hold-off on request so that the command queue
  // fills and the block pushes back on its input, and a steady tready once the closing
  // stretch begins.
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        m_tready <= 1'b0;
        repeat (150) @(posedge clk_i);
      end else if (quiet_tail) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // One APB write: setup cycle, then access until pready, then one idle cycle on the bus.
  // The upper data bits are random, since only the low 13 bits belong to a size register.
  task automatic write_size(input logic [APB_AW-1:0] addr, input logic [DIM_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(APB_DW-DIM_W)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_size(addr == REG_SRC_HEIGHT, value);
    @(posedge clk_i);
  endtask

  // Offers one pixel beat, sometimes after a gap, and returns at the edge that takes it.
  // tvalid is only lowered for a gap, so it is never dropped and raised in one step.
  task automatic feed_pixel(input logic [PIX_W-1:0] px);
    int gap;
    if (!quiet_tail && tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do @(posedge clk_i); while (!s_tready);
  endtask

  // Stops the source and waits until every predicted pixel has come out. The first edge
  // lets the monitor log the last beat; the trailing cycles cover an even-row pair sum
  // still on its way into the line store, so the block is idle for the next size write.
  task automatic settle_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic pixel_burst(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input int count);
    write_size(REG_SRC_WIDTH, w);
    write_size(REG_SRC_HEIGHT, h);
    repeat (count) feed_pixel($urandom);
    settle_results();
  endtask

  initial begin
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int               pick;
    int               count;
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset sizes first: a short run into the first row of the widest line, which only
    // fills line store entries and must emit nothing.
    tx_idle_odds = 6;
    repeat (48) feed_pixel($urandom);
    settle_results();

    // Smallest size that gives output. Saturated lanes, empty lanes and alternating bit
    // patterns, across two frame wraps, so each frame is a single row and frame end.
    write_size(REG_SRC_WIDTH, DIM_W'(2));
    write_size(REG_SRC_HEIGHT, DIM_W'(2));
    repeat (4) feed_pixel('1);
    repeat (4) feed_pixel('0);
    repeat (2) begin
      feed_pixel(32'hAAAA_AAAA);
      feed_pixel(32'h5555_5555);
    end
    settle_results();

    // Odd width and height: the trailing column and row are dropped.
    pixel_burst(DIM_W'(3), DIM_W'(3), 9);
    // Zero sizes count as one, and a single row or a single column emits nothing.
    pixel_burst(DIM_W'(0), DIM_W'(0), 3);
    pixel_burst(DIM_W'(4), DIM_W'(1), 4);
    pixel_burst(DIM_W'(1), DIM_W'(4), 4);

    // Long sink hold-off with the source offering beats back to back: the queue fills
    // and s_tready has to drop until the sink lets go.
    tx_idle_odds     = 0;
    hold_off_request = 1'b1;
    pixel_burst(DIM_W'(4), DIM_W'(4), 64);

    // Largest sizes, clamped from the top of the register range, over the first rows.
    tx_idle_odds = 6;
    pixel_burst(DIM_W'(2), '1, 40);
    pixel_burst('1, DIM_W'(2), 40);

    // Random frames. Mostly small sizes with whole frames and the odd run-on into the
    // next frame; some odd or degenerate sizes; now and then a wild size cut short.
    while (random_items < 300) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        w     = DIM_W'($urandom_range(2, 12));
        h     = DIM_W'($urandom_range(2, 8));
        count = int'(w) * int'(h) * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) begin
          count += $urandom_range(1, int'(w));
        end
      end else if (pick < 9) begin
        w     = DIM_W'($urandom_range(0, 40));
        h     = DIM_W'($urandom_range(0, 6));
        count = $urandom_range(1, 120);
      end else begin
        w     = DIM_W'($urandom);
        h     = DIM_W'($urandom);
        count = $urandom_range(1, 60);
      end
      tx_idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
      pixel_burst(w, h, count);
      random_items += count;
    end

    // Closing stretch with no idling on either side.
    quiet_tail = 1'b1;
    pixel_burst(DIM_W'(6), DIM_W'(6), 72);

    if (sb.mismatches == 0) begin
      $display("PASS box_downsample_2x2_argb_unit");
    end else begin
      $display("FAIL box_downsample_2x2_argb_unit");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #24000000;
    $display("FAIL box_downsample_2x2_argb_unit");
    $finish;
  end

endmodule
